### src/noos_pkg.sv
// Shared types and constants for the note onset/offset segmenter.
// Holds the state, configuration and event records and the velocity helper.
// No dependencies.
package noos_pkg;

    // Width of the frame counter and of stored frame indexes.
    localparam int FRAME_BITS = 16;
    localparam int EVENT_FRAME_BITS = 16;
    localparam int PITCH_BITS = 7;
    localparam int AMP_BITS = 16;
    localparam int VEL_BITS = 7;
    localparam int MAX_EVENTS = 4;
    localparam int EV_CNT_BITS = $clog2(MAX_EVENTS + 1);
    localparam int EV_IDX_BITS = $clog2(MAX_EVENTS);
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PLAY_THRESHOLD  = 2'd0,
        REG_STOP_THRESHOLD  = 2'd1,
        REG_MIN_NOTE_FRAMES = 2'd2,
        REG_VELOCITY_GAIN   = 2'd3
    } t_reg_idx;

    localparam logic KIND_NOTE_OFF = 1'b0;
    localparam logic KIND_NOTE_ON  = 1'b1;

    localparam logic [AMP_BITS-1:0] PLAY_THRESHOLD_RST  = 16'd640;
    localparam logic [AMP_BITS-1:0] STOP_THRESHOLD_RST  = 16'd256;
    localparam logic [7:0]          MIN_NOTE_FRAMES_RST = 8'd8;
    localparam logic [3:0]          VELOCITY_GAIN_RST   = 4'd3;

    typedef struct packed {
        logic [AMP_BITS-1:0] play_threshold;
        logic [AMP_BITS-1:0] stop_threshold;
        logic [7:0]          min_note_frames;
        logic [3:0]          velocity_gain;
    } t_cfg;

    typedef struct packed {
        t_frame                frame_count;
        logic [PITCH_BITS-1:0] tracked_pitch;
        logic [AMP_BITS-1:0]   peak_amp;
        t_frame                peak_frame;
        logic                  playing_flag;
        logic                  start_pending;
        logic                  stop_pending;
        logic                  any_emitted;
        logic                  first_loaded;
    } t_state;

    typedef struct packed {
        logic [AMP_BITS-1:0]   amplitude;
        logic [PITCH_BITS-1:0] this_pitch;
        logic [PITCH_BITS-1:0] next_pitch;
        logic                  next_is_final;
    } t_frame_in;

    typedef struct packed {
        logic                        event_kind;
        logic [EVENT_FRAME_BITS-1:0] event_frame;
        logic [PITCH_BITS-1:0]       note_pitch;
        logic [VEL_BITS-1:0]         velocity;
        logic                        last_of_run;
    } t_event;

    // Integer part of gain * Q8.8 amplitude, limited to 127.
    function automatic logic [VEL_BITS-1:0] velocity_of(input logic [3:0] gain,
                                                         input logic [AMP_BITS-1:0] amp);
        logic [AMP_BITS+3:0] prod;
        prod = (AMP_BITS + 4)'(gain) * (AMP_BITS + 4)'(amp);
        if (prod[AMP_BITS+3:8] > (AMP_BITS - 4)'(127)) begin
            return 7'd127;
        end
        return prod[14:8];
    endfunction

    // Frame index as reported on the event channel: low 16 bits of the counter.
    function automatic logic [EVENT_FRAME_BITS-1:0] event_frame_of(input t_frame f);
        logic [31:0] wide;
        wide = 32'(f);
        return wide[EVENT_FRAME_BITS-1:0];
    endfunction

endpackage

### src/noos_step.sv
// Single-pass update of the segmenter for one frame word.
// Computes the next state and up to four events; depends on noos_pkg.
module noos_step (
    input  noos_pkg::t_state                          i_state,
    input  noos_pkg::t_cfg                            i_cfg,
    input  noos_pkg::t_frame_in                       i_frame,
    output noos_pkg::t_state                          o_state,
    output noos_pkg::t_event [noos_pkg::MAX_EVENTS-1:0] o_events,
    output logic [noos_pkg::EV_CNT_BITS-1:0]          o_count
);

    always_comb begin
        noos_pkg::t_state                  s;
        noos_pkg::t_frame                  n;
        noos_pkg::t_frame                  len;
        noos_pkg::t_frame                  off_frame;
        logic [noos_pkg::PITCH_BITS-1:0]   pitch0;
        logic [noos_pkg::AMP_BITS-1:0]     amp0;
        logic                              same;
        logic                              to_play;
        logic                              to_stop;
        logic                              both;
        logic                              emit_pair;
        logic                              lone_off;
        logic                              flush;
        logic [noos_pkg::EV_CNT_BITS-1:0]  k;

        s = i_state;
        n = i_state.frame_count;
        k = '0;
        o_events = '0;

        if (!s.first_loaded) begin
            s.tracked_pitch = i_frame.this_pitch;
            s.peak_amp      = i_frame.amplitude;
            s.first_loaded  = 1'b1;
        end
        pitch0 = s.tracked_pitch;
        amp0   = s.peak_amp;

        same    = (s.tracked_pitch == i_frame.next_pitch);
        to_play = !s.start_pending && (s.peak_amp >= i_cfg.play_threshold) &&
                  (!s.any_emitted || !same || !s.playing_flag);
        to_stop = s.playing_flag &&
                  ((s.peak_amp < i_cfg.stop_threshold) || i_frame.next_is_final || !same);

        // A note armed at both ends is emitted if long enough, else dropped.
        both = s.start_pending && s.stop_pending;
        len = (n >= s.peak_frame) ? n - s.peak_frame : '0;
        emit_pair = both && (len > noos_pkg::FRAME_BITS'(i_cfg.min_note_frames));
        if (both) begin
            if (emit_pair) begin
                s.peak_frame = n;
                s.peak_amp   = i_frame.amplitude;
            end
            s.start_pending = 1'b0;
            s.stop_pending  = 1'b0;
            s.tracked_pitch = i_frame.this_pitch;
        end
        if (emit_pair) begin
            o_events[k[noos_pkg::EV_IDX_BITS-1:0]] = '{
                event_kind:  noos_pkg::KIND_NOTE_ON,
                event_frame: noos_pkg::event_frame_of(i_state.peak_frame),
                note_pitch:  pitch0,
                velocity:    noos_pkg::velocity_of(i_cfg.velocity_gain, amp0),
                last_of_run: 1'b0};
            k = k + 1'b1;
            o_events[k[noos_pkg::EV_IDX_BITS-1:0]] = '{
                event_kind:  noos_pkg::KIND_NOTE_OFF,
                event_frame: noos_pkg::event_frame_of(n),
                note_pitch:  pitch0,
                velocity:    '0,
                last_of_run: 1'b0};
            k = k + 1'b1;
        end

        // A stop with no start armed gives a note-off on its own.
        lone_off = s.stop_pending && !s.start_pending;
        if (lone_off) begin
            o_events[k[noos_pkg::EV_IDX_BITS-1:0]] = '{
                event_kind:  noos_pkg::KIND_NOTE_OFF,
                event_frame: noos_pkg::event_frame_of(n),
                note_pitch:  s.tracked_pitch,
                velocity:    '0,
                last_of_run: 1'b0};
            k = k + 1'b1;
            s.playing_flag = 1'b0;
            s.peak_amp     = '0;
            s.stop_pending = 1'b0;
        end

        if (!s.stop_pending && (s.peak_amp < i_frame.amplitude)) begin
            s.peak_amp   = i_frame.amplitude;
            s.peak_frame = n;
        end

        if (to_play) begin
            s.start_pending = 1'b1;
            s.playing_flag  = 1'b1;
            s.peak_frame    = n;
        end
        if (to_stop) begin
            s.stop_pending = 1'b1;
            s.playing_flag = 1'b0;
        end

        // Before the last frame, a fully armed note goes out with its off
        // time one frame later.
        flush = i_frame.next_is_final && s.start_pending && s.stop_pending;
        off_frame = (n != '1) ? n + 1'b1 : n;
        if (flush) begin
            o_events[k[noos_pkg::EV_IDX_BITS-1:0]] = '{
                event_kind:  noos_pkg::KIND_NOTE_ON,
                event_frame: noos_pkg::event_frame_of(s.peak_frame),
                note_pitch:  s.tracked_pitch,
                velocity:    noos_pkg::velocity_of(i_cfg.velocity_gain, s.peak_amp),
                last_of_run: 1'b0};
            k = k + 1'b1;
            o_events[k[noos_pkg::EV_IDX_BITS-1:0]] = '{
                event_kind:  noos_pkg::KIND_NOTE_OFF,
                event_frame: noos_pkg::event_frame_of(off_frame),
                note_pitch:  s.tracked_pitch,
                velocity:    '0,
                last_of_run: 1'b0};
            k = k + 1'b1;
            s.start_pending = 1'b0;
            s.stop_pending  = 1'b0;
        end

        if (k != '0) begin
            s.any_emitted = 1'b1;
            o_events[noos_pkg::EV_IDX_BITS'(k - 1'b1)].last_of_run = 1'b1;
        end

        if (n != '1) begin
            s.frame_count = n + 1'b1;
        end

        o_state = s;
        o_count = k;
    end

endmodule

### src/note_onset_offset_segmenter_top.sv
// Top level of the monophonic note onset/offset segmenter.
// Instantiates noos_step; depends on noos_pkg.
//
// Usage:
//   Frame words enter on the s_axis channel, one analysis frame per word.
//   Each frame causes zero to four note events, which leave on m_axis one
//   word per cycle while m_axis_tready is high; tlast marks the last event caused by a frame and tuser
//   carries the event kind (1 note on, 0 note off).
//   Thresholds, minimum note length and velocity gain are written through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata while the block is idle.
// Dataflow:
//   An accepted frame is held in the input register; the update runs
//   between that register and the four-entry event buffer, so the first
//   event is valid once the frame has been loaded into the buffer. A new
//   frame is taken from the input register only when the buffer is empty or
//   its last event is leaving through the single event output port.
// Reset and stalls:
//   Reset clears the segmenter state and restores the register defaults.
//   When m_axis_tready is low the buffer holds; the input register still
//   takes one more frame, after which s_axis_tready drops.
module note_onset_offset_segmenter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // amplitude[15:0], this_pitch[22:16], next_pitch[29:23], next_is_final[30]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_frame[15:0], note_pitch[22:16], velocity[29:23]
    output logic [31:0] m_axis_tdata,
    // event_kind[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [noos_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [noos_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);

    noos_pkg::t_cfg      r_cfg;
    noos_pkg::t_state    r_state;
    noos_pkg::t_state    n_state;
    noos_pkg::t_frame_in r_in;
    logic                r_in_valid;
    noos_pkg::t_event    r_ev [noos_pkg::MAX_EVENTS];
    logic [noos_pkg::EV_CNT_BITS-1:0] r_left;
    logic [noos_pkg::EV_IDX_BITS-1:0] r_rd;

    noos_pkg::t_event [noos_pkg::MAX_EVENTS-1:0] w_events;
    logic [noos_pkg::EV_CNT_BITS-1:0] w_count;
    logic w_out_fire;
    logic w_buf_free;
    logic w_take;
    noos_pkg::t_event w_head;

    assign w_out_fire = m_axis_tvalid && m_axis_tready;
    assign w_buf_free = (r_left == '0) || ((r_left == noos_pkg::EV_CNT_BITS'(1)) && w_out_fire);
    assign w_take = r_in_valid && w_buf_free;
    assign s_axis_tready = !r_in_valid || w_take;

    noos_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_frame  (r_in),
        .o_state  (n_state),
        .o_events (w_events),
        .o_count  (w_count)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play_threshold  <= noos_pkg::PLAY_THRESHOLD_RST;
            r_cfg.stop_threshold  <= noos_pkg::STOP_THRESHOLD_RST;
            r_cfg.min_note_frames <= noos_pkg::MIN_NOTE_FRAMES_RST;
            r_cfg.velocity_gain   <= noos_pkg::VELOCITY_GAIN_RST;
        end else if (i_cfg_we) begin
            case (noos_pkg::t_reg_idx'(i_cfg_addr))
                noos_pkg::REG_PLAY_THRESHOLD:  r_cfg.play_threshold  <= i_cfg_wdata;
                noos_pkg::REG_STOP_THRESHOLD:  r_cfg.stop_threshold  <= i_cfg_wdata;
                noos_pkg::REG_MIN_NOTE_FRAMES: r_cfg.min_note_frames <= i_cfg_wdata[7:0];
                noos_pkg::REG_VELOCITY_GAIN:   r_cfg.velocity_gain   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= '{
                amplitude:     s_axis_tdata[15:0],
                this_pitch:    s_axis_tdata[22:16],
                next_pitch:    s_axis_tdata[29:23],
                next_is_final: s_axis_tdata[30]};
        end
    end

    // Segmenter state advances once per frame taken from the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_take) begin
            r_state <= n_state;
        end
    end

    // Event buffer: loaded whole by one frame, drained one word per cycle while m_axis_tready is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rd   <= '0;
        end else if (w_take) begin
            r_left <= w_count;
            r_rd   <= '0;
        end else if (w_out_fire) begin
            r_left <= r_left - 1'b1;
            r_rd   <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < noos_pkg::MAX_EVENTS; i++) begin
                r_ev[i] <= w_events[i];
            end
        end
    end

    assign w_head        = r_ev[r_rd];
    assign m_axis_tvalid = (r_left != '0);
    assign m_axis_tdata  = {2'b00, w_head.velocity, w_head.note_pitch, w_head.event_frame};
    assign m_axis_tuser  = w_head.event_kind;
    assign m_axis_tlast  = w_head.last_of_run;

    // The buffer never holds more events than one frame can cause.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= noos_pkg::EV_CNT_BITS'(noos_pkg::MAX_EVENTS))
        else $error("event buffer count out of range");

    // The stored last-of-run mark agrees with the drain count.
    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_left == noos_pkg::EV_CNT_BITS'(1))))
        else $error("tlast does not match remaining event count");

    // A new frame is processed only when the buffer is empty or its last event is leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ((r_left == '0) || ((r_left == noos_pkg::EV_CNT_BITS'(1)) && w_out_fire)))
        else $error("event buffer overwritten before drained");

    // The peak frame never runs ahead of the frame counter.
    a_peak_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.peak_frame <= r_state.frame_count)
        else $error("peak frame beyond frame counter");

endmodule

### sim/noos_checker.sv
// Scoreboard for the note onset/offset segmenter: watches the frame, event and
// register ports, predicts the note events of every accepted frame and compares.
// Depends on noos_pkg for the register indexes, event record and widths.
module noos_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // amplitude[15:0], this_pitch[22:16], next_pitch[29:23], next_is_final[30]
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_frame[15:0], note_pitch[22:16], velocity[29:23]
    input  logic [31:0] m_axis_tdata,
    // event_kind[0]
    input  logic [0:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [noos_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [noos_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam noos_pkg::t_frame FRAME_TOP = '1;

    noos_pkg::t_cfg                  cfg;
    noos_pkg::t_frame                frame_idx;
    noos_pkg::t_frame                peak_frm;
    logic [noos_pkg::PITCH_BITS-1:0] cur_pitch;
    logic [noos_pkg::AMP_BITS-1:0]   peak_lvl;
    logic                            playing;
    logic                            start_armed;
    logic                            stop_armed;
    logic                            emitted_any;
    logic                            loaded;

    noos_pkg::t_event note_events_due[$];
    noos_pkg::t_event run_buf[noos_pkg::MAX_EVENTS];
    int               run_len;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch(what, int'(got), int'(want));
        end
    endtask

    function automatic logic [noos_pkg::VEL_BITS-1:0] note_velocity(
            input logic [noos_pkg::AMP_BITS-1:0] amp);
        logic [noos_pkg::AMP_BITS+3:0] prod;
        prod = 20'(cfg.velocity_gain) * 20'(amp);
        if ((prod >> 8) > 20'd127) begin
            return 7'd127;
        end
        return prod[14:8];
    endfunction

    task automatic add_event(input logic kind, input noos_pkg::t_frame frm,
                             input logic [noos_pkg::VEL_BITS-1:0] vel);
        noos_pkg::t_event ev;
        ev.event_kind  = kind;
        ev.event_frame = frm[noos_pkg::EVENT_FRAME_BITS-1:0];
        ev.note_pitch  = cur_pitch;
        ev.velocity    = vel;
        ev.last_of_run = 1'b0;
        if (run_len < noos_pkg::MAX_EVENTS) begin
            run_buf[run_len] = ev;
            run_len++;
        end
        emitted_any = 1'b1;
    endtask

    // One analysis frame: update the note tracker and queue the events it causes.
    task automatic segment_frame(input logic [31:0] word);
        logic [noos_pkg::AMP_BITS-1:0]   amp;
        logic [noos_pkg::PITCH_BITS-1:0] tp;
        logic [noos_pkg::PITCH_BITS-1:0] np;
        logic                            fin;
        logic                            same;
        logic                            to_play;
        logic                            to_stop;
        noos_pkg::t_frame                n;
        noos_pkg::t_frame                len;
        noos_pkg::t_frame                off;
        amp     = word[15:0];
        tp      = word[22:16];
        np      = word[29:23];
        fin     = word[30];
        n       = frame_idx;
        run_len = 0;

        if (!loaded) begin
            cur_pitch = tp;
            peak_lvl  = amp;
            loaded    = 1'b1;
        end

        same    = (cur_pitch == np);
        to_play = !start_armed && peak_lvl >= cfg.play_threshold &&
                  (!emitted_any || !same || !playing);
        to_stop = playing && (peak_lvl < cfg.stop_threshold || fin || !same);

        if (start_armed && stop_armed) begin
            len = (n >= peak_frm) ? n - peak_frm : '0;
            // Notes no longer than the minimum length are dropped silently.
            if (len > noos_pkg::t_frame'(cfg.min_note_frames)) begin
                add_event(noos_pkg::KIND_NOTE_ON, peak_frm, note_velocity(peak_lvl));
                add_event(noos_pkg::KIND_NOTE_OFF, n, '0);
                peak_frm = n;
                peak_lvl = amp;
            end
            start_armed = 1'b0;
            stop_armed  = 1'b0;
            cur_pitch   = tp;
        end

        if (stop_armed && !start_armed) begin
            add_event(noos_pkg::KIND_NOTE_OFF, n, '0);
            playing    = 1'b0;
            peak_lvl   = '0;
            stop_armed = 1'b0;
        end

        if (!stop_armed && peak_lvl < amp) begin
            peak_lvl = amp;
            peak_frm = n;
        end

        if (to_play) begin
            start_armed = 1'b1;
            playing     = 1'b1;
            peak_frm    = n;
        end
        if (to_stop) begin
            stop_armed = 1'b1;
            playing    = 1'b0;
        end

        // The frame before the last one flushes an armed note without a length check.
        if (fin && start_armed && stop_armed) begin
            off = (n < FRAME_TOP) ? n + 1'b1 : n;
            add_event(noos_pkg::KIND_NOTE_ON, peak_frm, note_velocity(peak_lvl));
            add_event(noos_pkg::KIND_NOTE_OFF, off, '0);
            start_armed = 1'b0;
            stop_armed  = 1'b0;
        end

        if (frame_idx < FRAME_TOP) begin
            frame_idx++;
        end

        for (int k = 0; k < run_len; k++) begin
            if (k == run_len - 1) begin
                run_buf[k].last_of_run = 1'b1;
            end
            note_events_due = {note_events_due, run_buf[k]};
        end
    endtask

    always @(posedge i_clk) begin
        noos_pkg::t_event want;
        if (!i_rst_n) begin
            cfg.play_threshold  = noos_pkg::PLAY_THRESHOLD_RST;
            cfg.stop_threshold  = noos_pkg::STOP_THRESHOLD_RST;
            cfg.min_note_frames = noos_pkg::MIN_NOTE_FRAMES_RST;
            cfg.velocity_gain   = noos_pkg::VELOCITY_GAIN_RST;
            frame_idx   = '0;
            peak_frm    = '0;
            cur_pitch   = '0;
            peak_lvl    = '0;
            playing     = 1'b0;
            start_armed = 1'b0;
            stop_armed  = 1'b0;
            emitted_any = 1'b0;
            loaded      = 1'b0;
            note_events_due.delete();
        end else begin
            // Events at this edge always belong to frames accepted earlier.
            if (m_axis_tvalid && m_axis_tready) begin
                if (note_events_due.size() == 0) begin
                    report_mismatch("event word with none expected, frame",
                                    int'(m_axis_tdata[15:0]), -1);
                end else begin
                    want = note_events_due.pop_front();
                    check_field("event_kind", 16'(m_axis_tuser[0]), 16'(want.event_kind));
                    check_field("event_frame", m_axis_tdata[15:0], want.event_frame);
                    check_field("note_pitch", 16'(m_axis_tdata[22:16]),
                                16'(want.note_pitch));
                    check_field("velocity", 16'(m_axis_tdata[29:23]), 16'(want.velocity));
                    check_field("last_of_run", 16'(m_axis_tlast), 16'(want.last_of_run));
                end
            end
            if (i_cfg_we) begin
                case (noos_pkg::t_reg_idx'(i_cfg_addr))
                    noos_pkg::REG_PLAY_THRESHOLD:  cfg.play_threshold  = i_cfg_wdata;
                    noos_pkg::REG_STOP_THRESHOLD:  cfg.stop_threshold  = i_cfg_wdata;
                    noos_pkg::REG_MIN_NOTE_FRAMES: cfg.min_note_frames = i_cfg_wdata[7:0];
                    noos_pkg::REG_VELOCITY_GAIN:   cfg.velocity_gain   = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                segment_frame(s_axis_tdata);
            end
        end
        o_pending = note_events_due.size();
    end

endmodule

### sim/tb_top.sv
// Top of the segmenter testbench: clock, reset, frame and register stimulus,
// receiver back-pressure and the final verdict. Checking lives in noos_checker.
// Depends on noos_pkg, note_onset_offset_segmenter_top and noos_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [noos_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [noos_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int frames_sent;

    logic        idle_on;
    logic        hold_req;
    logic        hold_done;
    logic [15:0] cur_play;
    logic [15:0] cur_stop;

    note_onset_offset_segmenter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    noos_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #16_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off while frames keep coming.
    initial begin
        int stall_left;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (150) @(negedge i_clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_frame(input logic [15:0] amp, input logic [6:0] tp,
                              input logic [6:0] np, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, fin, np, tp, amp};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        frames_sent++;
    endtask

    // Wait until every expected event is out and the input register has drained.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] play, input logic [15:0] stop,
                              input logic [7:0] min_frames, input logic [3:0] gain);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= noos_pkg::REG_PLAY_THRESHOLD;
        i_cfg_wdata <= play;
        @(negedge i_clk);
        i_cfg_addr  <= noos_pkg::REG_STOP_THRESHOLD;
        i_cfg_wdata <= stop;
        @(negedge i_clk);
        // Upper bits of the narrow registers carry junk that must be ignored.
        i_cfg_addr  <= noos_pkg::REG_MIN_NOTE_FRAMES;
        i_cfg_wdata <= {8'($urandom), min_frames};
        @(negedge i_clk);
        i_cfg_addr  <= noos_pkg::REG_VELOCITY_GAIN;
        i_cfg_wdata <= {12'($urandom), gain};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_play = play;
        cur_stop = stop;
    endtask

    // A run of notes: attack mostly at or above the play level, decay, a short
    // quiet tail, next_pitch taken from the following frame and the final flag
    // near the end. A few frames get a corrupted field.
    task automatic send_stream(input int n);
        logic [15:0] amps[$];
        logic [6:0]  pits[$];
        logic [15:0] lvl;
        logic [15:0] fall;
        logic [6:0]  p;
        logic [6:0]  np;
        logic        fin;
        logic [15:0] amp;
        int          len;
        int          r;
        while (amps.size() < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 10);
            if (pits.size() > 0 && $urandom_range(0, 3) == 0) begin
                p = pits[pits.size() - 1];
            end else begin
                p = 7'($urandom_range(0, 127));
            end
            if ($urandom_range(0, 3) == 0) begin
                lvl = 16'($urandom);
            end else begin
                lvl = 16'($urandom_range(32'(cur_play), 65535));
            end
            fall = 16'($urandom_range(0, 32'(lvl) / (len + 1)));
            for (int i = 0; i < len; i++) begin
                amps = {amps, lvl};
                pits = {pits, p};
                lvl = lvl - fall;
            end
            repeat ($urandom_range(0, 3)) begin
                amp = (cur_stop == 0) ? 16'd0 :
                      16'($urandom_range(0, 32'(cur_stop) - 1));
                amps = {amps, amp};
                pits = {pits, p};
            end
        end
        for (int i = 0; i < n; i++) begin
            amp = amps[i];
            np  = (i + 1 < n) ? pits[i + 1] : 7'($urandom_range(0, 127));
            fin = (i == n - 2);
            r   = $urandom_range(0, 19);
            if (r == 0) begin
                amp = 16'($urandom);
            end else if (r == 1) begin
                np = 7'($urandom_range(0, 127));
            end else if (r == 2) begin
                fin = ~fin;
            end
            send_frame(amp, pits[i], np, fin);
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = frames_sent;
        while (frames_sent - start < target) begin
            send_stream($urandom_range(12, 40));
        end
    endtask

    task automatic random_config();
        logic [15:0] play;
        play = 16'($urandom_range(256, 2048));
        set_config(play, 16'($urandom_range(0, 32'(play))),
                   8'($urandom_range(0, 6)), 4'($urandom_range(0, 15)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = noos_pkg::REG_PLAY_THRESHOLD;
        i_cfg_wdata   = '0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        cur_play      = noos_pkg::PLAY_THRESHOLD_RST;
        cur_stop      = noos_pkg::STOP_THRESHOLD_RST;
        frames_sent   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames on the reset settings. The first one loads pitch and
        // peak; a long loud note ends on a pitch change.
        send_frame(16'hFFFF, 7'd127, 7'd127, 1'b0);
        repeat (9) send_frame(16'h0300, 7'd127, 7'd127, 1'b0);
        send_frame(16'h0000, 7'd127, 7'd0, 1'b0);
        send_frame(16'h0000, 7'd0, 7'd0, 1'b0);
        // A short note that is too brief to be kept.
        send_frame(16'h0400, 7'd0, 7'd0, 1'b0);
        send_frame(16'h0400, 7'd0, 7'd0, 1'b0);
        send_frame(16'h0100, 7'd0, 7'd5, 1'b0);
        send_frame(16'h0000, 7'd5, 7'd5, 1'b0);
        // Falling level under the stop threshold, then a final-frame flush.
        send_frame(16'h0A00, 7'd5, 7'd5, 1'b0);
        send_frame(16'h00FF, 7'd5, 7'd5, 1'b0);
        send_frame(16'h0001, 7'd5, 7'd5, 1'b0);
        send_frame(16'h0800, 7'd5, 7'd5, 1'b0);
        send_frame(16'h0900, 7'd5, 7'd5, 1'b0);
        send_frame(16'h0900, 7'd5, 7'd9, 1'b1);
        send_frame(16'h0001, 7'd9, 7'd9, 1'b0);
        settle();

        // The receiver holds off early in this phase so the block backs up.
        random_config();
        hold_req <= 1'b1;
        run_phase(25);
        settle();
        set_config(16'd0, 16'd0, 8'd0, 4'd0);
        run_phase(20);
        settle();
        set_config(16'hFFFF, 16'hFFFF, 8'd255, 4'd15);
        run_phase(20);
        settle();
        idle_on <= 1'b0;
        set_config(16'd0, 16'hFFFF, 8'd0, 4'd15);
        run_phase(20);
        settle();
        idle_on <= 1'b1;
        random_config();
        run_phase(25);
        settle();

        set_config(noos_pkg::PLAY_THRESHOLD_RST, noos_pkg::STOP_THRESHOLD_RST,
                   noos_pkg::MIN_NOTE_FRAMES_RST, noos_pkg::VELOCITY_GAIN_RST);
        send_stream(24);
        settle();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
src/noos_pkg.sv
src/noos_step.sv
src/note_onset_offset_segmenter_top.sv
sim/noos_checker.sv
sim/tb_top.sv
